// ===== hdl/lcc_pkg.sv =====
package lcc_pkg;

  localparam int CHANNEL_BITS   = 12;
  localparam int COEF_FRAC_BITS = 14;

  localparam int  FS      = (1 << CHANNEL_BITS) - 1;
  localparam longint YI_BASE = longint'(FS) << COEF_FRAC_BITS;

  // coefficient magnitudes stay below 4.0
  localparam int COEF_W = COEF_FRAC_BITS + 3;
  localparam int PROD_W = CHANNEL_BITS + 1 + COEF_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int P2_W   = SUM_W + COEF_W;
  localparam int ACC_W  = P2_W + 2;
  localparam int RGB_W  = ACC_W - 2 * COEF_FRAC_BITS;
  localparam int ADJ_W  = RGB_W + 1;
  localparam int SH_W   = RGB_W + 2;

  localparam int NSTG = 6;

  // round-half-up of n * 1e-5 scaled by 2^COEF_FRAC_BITS
  function automatic longint kq(input longint n);
    return (n * (longint'(1) << COEF_FRAC_BITS) + 50000) / 100000;
  endfunction

  localparam logic signed [COEF_W-1:0] K_YR = COEF_W'(kq(21260));
  localparam logic signed [COEF_W-1:0] K_YG = COEF_W'(kq(71520));
  localparam logic signed [COEF_W-1:0] K_YB = COEF_W'(kq(7220));
  localparam logic signed [COEF_W-1:0] K_UR = COEF_W'(kq(9991));
  localparam logic signed [COEF_W-1:0] K_UG = COEF_W'(kq(33609));
  localparam logic signed [COEF_W-1:0] K_UB = COEF_W'(kq(43600));
  localparam logic signed [COEF_W-1:0] K_VR = COEF_W'(kq(61500));
  localparam logic signed [COEF_W-1:0] K_VG = COEF_W'(kq(55861));
  localparam logic signed [COEF_W-1:0] K_VB = COEF_W'(kq(5639));
  localparam logic signed [COEF_W-1:0] K_RV = COEF_W'(kq(128033));
  localparam logic signed [COEF_W-1:0] K_GU = COEF_W'(kq(21482));
  localparam logic signed [COEF_W-1:0] K_GV = COEF_W'(kq(38059));
  localparam logic signed [COEF_W-1:0] K_BU = COEF_W'(kq(212798));

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red_in;
    logic [CHANNEL_BITS-1:0] green_in;
    logic [CHANNEL_BITS-1:0] blue_in;
  } pix_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red_out;
    logic [CHANNEL_BITS-1:0] green_out;
    logic [CHANNEL_BITS-1:0] blue_out;
  } lbl_t;

  // rounded channels plus the common shift
  typedef struct packed {
    logic signed [RGB_W-1:0] red;
    logic signed [RGB_W-1:0] green;
    logic signed [RGB_W-1:0] blue;
    logic signed [ADJ_W-1:0] adj;
  } shift_t;

endpackage

// ===== hdl/lcc_finish.sv =====
module lcc_finish (
  input  lcc_pkg::shift_t sh,
  output lcc_pkg::lbl_t   res
);
  import lcc_pkg::*;

  function automatic logic [CHANNEL_BITS-1:0] fin(input logic signed [RGB_W-1:0] c,
                                                  input logic signed [ADJ_W-1:0] a);
    logic signed [SH_W-1:0] s;
    logic signed [SH_W-1:0] m;
    s = SH_W'(c) + SH_W'(a);
    m = (s < 0) ? -s : s;
    return (m > SH_W'(FS)) ? CHANNEL_BITS'(FS) : m[CHANNEL_BITS-1:0];
  endfunction

  always_comb begin
    res.red_out   = fin(sh.red, sh.adj);
    res.green_out = fin(sh.green, sh.adj);
    res.blue_out  = fin(sh.blue, sh.adj);
  end

endmodule

// ===== hdl/luma_inverted_contrast_color.sv =====
// channel | beat     | handshake             | payload
// pix     | in       | pix_valid / pix_stall | red_in, green_in, blue_in
// lbl     | out      | lbl_valid / lbl_stall | red_out, green_out, blue_out
//
// Six register stages: YUV products, YUV sums, RGB products, RGB sums and
// rounding, min/max shift, finish. One pixel per clock while no stall holds the pipeline.
// Reset clears only the stage valid bits.
// A stalled output stage holds; empty stages upstream keep filling, so pix
// stalls only once every stage holds a beat.
module luma_inverted_contrast_color (
  input  logic          clk,
  input  logic          rst,
  input  logic          pix_valid,
  output logic          pix_stall,
  input  lcc_pkg::pix_t pix,
  output logic          lbl_valid,
  input  logic          lbl_stall,
  output lcc_pkg::lbl_t lbl
);
  import lcc_pkg::*;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] en;
  logic [NSTG-1:0] vld_in;

  // stage 1
  logic signed [PROD_W-1:0] p_yr, p_yg, p_yb, p_ur, p_ug, p_ub, p_vr, p_vg, p_vb;
  // stage 2
  logic signed [SUM_W-1:0] u2, v2, yi2;
  // stage 3
  logic signed [P2_W-1:0] m_rv, m_gu, m_gv, m_bu;
  logic signed [SUM_W-1:0] yi3;
  // stage 4
  logic signed [RGB_W-1:0] rr4, gg4, bb4;
  // stage 5
  shift_t sh5;

  logic signed [CHANNEL_BITS:0] r_x, g_x, b_x;
  logic signed [SUM_W-1:0] y_c;
  logic signed [ACC_W-1:0] yi_w, acc_r, acc_g, acc_b;
  logic signed [RGB_W-1:0] over_c, under_c;
  logic signed [ADJ_W-1:0] adj_c;
  lbl_t fin_c;

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (2 * COEF_FRAC_BITS - 1);

  // a stage loads when it is empty or the next one moves
  always_comb begin
    en[NSTG-1] = !vld[NSTG-1] || !lbl_stall;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign vld_in    = {vld[NSTG-2:0], pix_valid};
  assign pix_stall = !en[0];
  assign lbl_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < NSTG; i++) begin
        if (en[i]) vld[i] <= vld_in[i];
      end
    end
  end

  assign r_x = $signed({1'b0, pix.red_in});
  assign g_x = $signed({1'b0, pix.green_in});
  assign b_x = $signed({1'b0, pix.blue_in});

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p_yr <= r_x * K_YR;
      p_yg <= g_x * K_YG;
      p_yb <= b_x * K_YB;
      p_ur <= r_x * K_UR;
      p_ug <= g_x * K_UG;
      p_ub <= b_x * K_UB;
      p_vr <= r_x * K_VR;
      p_vg <= g_x * K_VG;
      p_vb <= b_x * K_VB;
    end
  end

  assign y_c = SUM_W'(p_yr) + SUM_W'(p_yg) + SUM_W'(p_yb);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      u2  <= SUM_W'(p_ub) - SUM_W'(p_ur) - SUM_W'(p_ug);
      v2  <= SUM_W'(p_vr) - SUM_W'(p_vg) - SUM_W'(p_vb);
      yi2 <= SUM_W'(YI_BASE) - y_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      m_rv <= v2 * K_RV;
      m_gu <= u2 * K_GU;
      m_gv <= v2 * K_GV;
      m_bu <= u2 * K_BU;
      yi3  <= yi2;
    end
  end

  // rounding: add half, then floor by dropping the fraction bits
  always_comb begin
    yi_w  = ACC_W'(yi3) <<< COEF_FRAC_BITS;
    acc_r = yi_w + ACC_W'(m_rv) + RND_HALF;
    acc_g = yi_w - ACC_W'(m_gu) - ACC_W'(m_gv) + RND_HALF;
    acc_b = yi_w + ACC_W'(m_bu) + RND_HALF;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      rr4 <= acc_r[ACC_W-1:2*COEF_FRAC_BITS];
      gg4 <= acc_g[ACC_W-1:2*COEF_FRAC_BITS];
      bb4 <= acc_b[ACC_W-1:2*COEF_FRAC_BITS];
    end
  end

  always_comb begin
    over_c = rr4;
    if (gg4 > over_c) over_c = gg4;
    if (bb4 > over_c) over_c = bb4;
    under_c = rr4;
    if (gg4 < under_c) under_c = gg4;
    if (bb4 < under_c) under_c = bb4;
    if (over_c > RGB_W'(FS)) begin
      adj_c = ADJ_W'(FS) - ADJ_W'(over_c);
    end else if (under_c < 0) begin
      adj_c = -ADJ_W'(under_c);
    end else begin
      adj_c = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      sh5.red   <= rr4;
      sh5.green <= gg4;
      sh5.blue  <= bb4;
      sh5.adj   <= adj_c;
    end
  end

  lcc_finish u_finish (
    .sh  (sh5),
    .res (fin_c)
  );

  always_ff @(posedge clk) begin
    if (en[5]) lbl <= fin_c;
  end

  // stage-5 check helpers
  logic signed [SH_W-1:0] chk_hi, chk_lo;
  always_comb begin
    chk_hi = SH_W'(sh5.red) + SH_W'(sh5.adj);
    if (SH_W'(sh5.green) + SH_W'(sh5.adj) > chk_hi) chk_hi = SH_W'(sh5.green) + SH_W'(sh5.adj);
    if (SH_W'(sh5.blue) + SH_W'(sh5.adj) > chk_hi) chk_hi = SH_W'(sh5.blue) + SH_W'(sh5.adj);
    chk_lo = SH_W'(sh5.red) + SH_W'(sh5.adj);
    if (SH_W'(sh5.green) + SH_W'(sh5.adj) < chk_lo) chk_lo = SH_W'(sh5.green) + SH_W'(sh5.adj);
    if (SH_W'(sh5.blue) + SH_W'(sh5.adj) < chk_lo) chk_lo = SH_W'(sh5.blue) + SH_W'(sh5.adj);
  end

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (vld == '1 && lbl_stall) |-> pix_stall)
    else $error("full pipeline did not stall input");

  a_beat_count: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> $countones(vld) == $countones($past(vld))
      + ($past(pix_valid && !pix_stall) ? 1 : 0)
      - ($past(lbl_valid && !lbl_stall) ? 1 : 0))
    else $error("beat lost or duplicated in pipeline");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    (pix_valid && !pix_stall) |=> vld[0])
    else $error("accepted beat missing in first stage");

  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    vld[4] |-> (chk_hi <= SH_W'(FS)) || (chk_lo == '0))
    else $error("shift leaves channels out of range");

endmodule

// ===== sim/tb_luma_inverted_contrast_color.sv =====
module tb_luma_inverted_contrast_color;
  import lcc_pkg::*;

  typedef enum {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} idle_t;

  localparam int F           = COEF_FRAC_BITS;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 20;
  localparam int MAX_REPORTS = 10;

  // coefficient magnitudes in units of 1e-5, rounded half up to F fraction bits
  function automatic longint fixq(input longint e5);
    return (e5 * (longint'(1) << F) + 50000) / 100000;
  endfunction

  localparam longint C_YR = fixq(21260);
  localparam longint C_YG = fixq(71520);
  localparam longint C_YB = fixq(7220);
  localparam longint C_UR = fixq(9991);
  localparam longint C_UG = fixq(33609);
  localparam longint C_UB = fixq(43600);
  localparam longint C_VR = fixq(61500);
  localparam longint C_VG = fixq(55861);
  localparam longint C_VB = fixq(5639);
  localparam longint C_RV = fixq(128033);
  localparam longint C_GU = fixq(21482);
  localparam longint C_GV = fixq(38059);
  localparam longint C_BU = fixq(212798);

  logic  clk;
  logic  rst;
  logic  pix_valid;
  logic  pix_stall;
  pix_t  pix;
  logic  lbl_valid;
  logic  lbl_stall;
  lbl_t  lbl;

  lbl_t  expected_labels[$];
  idle_t send_mode;
  idle_t recv_mode;
  int    mismatches;
  int    errors;
  int    cycles;
  int    stall_left;
  int    stall_len;

  luma_inverted_contrast_color dut (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .lbl_valid (lbl_valid),
    .lbl_stall (lbl_stall),
    .lbl       (lbl)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // round with 2F fraction bits, half toward +infinity
  function automatic longint round_2f(input longint x);
    return (x + (longint'(1) <<< (2 * F - 1))) >>> (2 * F);
  endfunction

  function automatic logic [CHANNEL_BITS-1:0] fold_channel(input longint c);
    longint m;
    m = (c < 0) ? -c : c;
    if (m > FS) m = FS;
    return m[CHANNEL_BITS-1:0];
  endfunction

  function automatic lbl_t predict_label(input pix_t p);
    longint r, g, b, y, u, v, yi, rr, gg, bb, hi, lo, shift;
    lbl_t   o;
    r = p.red_in;
    g = p.green_in;
    b = p.blue_in;
    y = C_YR * r + C_YG * g + C_YB * b;
    u = -C_UR * r - C_UG * g + C_UB * b;
    v = C_VR * r - C_VG * g - C_VB * b;
    yi = ((longint'(FS) << F) - y) <<< F;
    rr = round_2f(yi + C_RV * v);
    gg = round_2f(yi - C_GU * u - C_GV * v);
    bb = round_2f(yi + C_BU * u);
    hi = rr;
    if (gg > hi) hi = gg;
    if (bb > hi) hi = bb;
    lo = rr;
    if (gg < lo) lo = gg;
    if (bb < lo) lo = bb;
    if (hi > FS) shift = FS - hi;
    else if (lo < 0) shift = -lo;
    else shift = 0;
    o.red_out   = fold_channel(rr + shift);
    o.green_out = fold_channel(gg + shift);
    o.blue_out  = fold_channel(bb + shift);
    return o;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int idle_len(input idle_t m);
    int r;
    r = $urandom_range(0, 99);
    case (m)
      IDLE_NONE: return 0;
      IDLE_LIGHT: begin
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(4, 12);
      end
      default: begin
        if (r < 40) return 0;
        if (r < 80) return $urandom_range(1, 4);
        if (r < 95) return $urandom_range(5, 15);
        return $urandom_range(16, 40);
      end
    endcase
  endfunction

  function automatic logic [CHANNEL_BITS-1:0] rand_channel();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      6:       return '0;
      7:       return CHANNEL_BITS'(FS);
      8:       return CHANNEL_BITS'($urandom_range(0, 15));
      9:       return CHANNEL_BITS'(FS - $urandom_range(0, 15));
      default: return CHANNEL_BITS'($urandom);
    endcase
  endfunction

  function automatic pix_t rand_pixel();
    pix_t p;
    int   r;
    r = $urandom_range(0, 9);
    p.red_in   = rand_channel();
    p.green_in = rand_channel();
    p.blue_in  = rand_channel();
    // grays sit right on the luma inversion boundary
    if (r >= 8) begin
      p.green_in = p.red_in;
      p.blue_in  = p.red_in;
    end
    return p;
  endfunction

  function automatic pix_t mk(input int r, input int g, input int b);
    pix_t p;
    p.red_in   = CHANNEL_BITS'(r);
    p.green_in = CHANNEL_BITS'(g);
    p.blue_in  = CHANNEL_BITS'(b);
    return p;
  endfunction

  task automatic send_pixel(input pix_t p);
    int gap;
    gap = idle_len(send_mode);
    if (gap > 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_valid <= 1'b1;
    pix       <= p;
    do @(posedge clk); while (pix_stall);
    expected_labels.push_back(predict_label(p));
  endtask

  task automatic hold_until_drained();
    pix_valid <= 1'b0;
    do @(posedge clk); while (expected_labels.size() != 0);
  endtask

  task automatic test_color_extremes();
    send_mode = IDLE_NONE;
    recv_mode = IDLE_NONE;
    send_pixel(mk(0, 0, 0));
    send_pixel(mk(FS, FS, FS));
    send_pixel(mk(FS, 0, 0));
    send_pixel(mk(0, FS, 0));
    send_pixel(mk(0, 0, FS));
    send_pixel(mk(0, FS, FS));
    send_pixel(mk(FS, 0, FS));
    send_pixel(mk(FS, FS, 0));
    send_pixel(mk(2048, 2048, 2048));
    send_pixel(mk(2047, 2047, 2047));
    send_pixel(mk(1, 1, 1));
    send_pixel(mk(FS - 1, FS - 1, FS - 1));
    send_pixel(mk(12'hAAA, 12'h555, 12'hAAA));
    send_pixel(mk(12'h555, 12'hAAA, 12'h555));
    send_pixel(mk(FS, 1, 0));
    send_pixel(mk(0, 1, FS));
    send_pixel(mk(FS, FS, 1));
    send_pixel(mk(1024, 3072, 512));
    send_pixel(mk(4000, 100, 3000));
    send_pixel(mk(0, 2048, 0));
    hold_until_drained();
  endtask

  task automatic test_random_stream(input int n, input idle_t s_mode, input idle_t r_mode);
    send_mode = s_mode;
    recv_mode = r_mode;
    repeat (n) send_pixel(rand_pixel());
    hold_until_drained();
  endtask

  // sender waits for every label before each burst
  task automatic test_pause_until_drained();
    send_mode = IDLE_NONE;
    recv_mode = IDLE_LIGHT;
    repeat (10) begin
      repeat (8) send_pixel(rand_pixel());
      hold_until_drained();
    end
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      lbl_stall <= 1'b1;
    end else begin
      stall_len = idle_len(recv_mode);
      lbl_stall <= (stall_len > 0);
      stall_left = (stall_len > 0) ? stall_len - 1 : 0;
    end
  end

  always @(posedge clk) begin
    if (!rst && lbl_valid && !lbl_stall) begin
      if (expected_labels.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("label beat with nothing pending: %h %h %h",
                   lbl.red_out, lbl.green_out, lbl.blue_out);
      end else if (lbl !== expected_labels[0]) begin
        errors++;
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("label mismatch: exp r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                   expected_labels[0].red_out, expected_labels[0].green_out,
                   expected_labels[0].blue_out, lbl.red_out, lbl.green_out,
                   lbl.blue_out);
        void'(expected_labels.pop_front());
      end else begin
        void'(expected_labels.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout, %0d labels pending", expected_labels.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    mismatches = 0;
    errors     = 0;
    cycles     = 0;
    stall_left = 0;
    send_mode  = IDLE_NONE;
    recv_mode  = IDLE_NONE;
    rst       <= 1'b1;
    pix_valid <= 1'b0;
    pix       <= '0;
    lbl_stall <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_color_extremes();
    test_random_stream(300, IDLE_NONE, IDLE_NONE);
    test_random_stream(300, IDLE_LIGHT, IDLE_LIGHT);
    test_random_stream(300, IDLE_HEAVY, IDLE_HEAVY);
    test_pause_until_drained();
    test_random_stream(120, IDLE_NONE, IDLE_HEAVY);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_labels.size() != 0) errors++;
    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
